// File: src/lkvc_pkg.sv
// -----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the least-recently-used key-value cache:
// table geometry, payload types and the command group that runs from the
// controller to the datapath.
// -----------------------------------------------------------------------------
package lkvc_pkg;

	// Table geometry.
	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// Field widths.
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;
	localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CAP_W-1:0]         cap_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	localparam cap_t CAP_RESET = CAP_W'(16);

	// Operation codes of a request.
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the incoming request
		logic decide;   // register the lookup outcome
		logic commit;   // apply the table update and load the result
	} cmd_t;

endpackage

// File: src/lkvc_ctrl.sv
// -----------------------------------------------------------------------------
// lkvc_ctrl
// Controller state machine: sequences capture, lookup and commit for each
// request and owns both handshakes, including the result valid flag.
// -----------------------------------------------------------------------------
module lkvc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output lkvc_pkg::cmd_t cmd
);
	import lkvc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_LOOKUP = 3'b010,
		S_UPDATE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	// The result register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;

	// A new request is taken when idle, or when the current one finishes.
	assign in_stall  = !((state_q == S_IDLE) || ((state_q == S_UPDATE) && out_free));
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Commands to the datapath.
	always_comb begin
		cmd.capture = accept;
		cmd.decide  = (state_q == S_LOOKUP);
		cmd.commit  = (state_q == S_UPDATE) && out_free;
	end

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_next = S_LOOKUP;
			end
			S_LOOKUP: begin
				state_next = S_UPDATE;
			end
			S_UPDATE: begin
				if (out_free) state_next = accept ? S_LOOKUP : S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// State and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A stalled result blocks completion of the request in hand.
	a_update_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE) && out_valid_q && out_stall |=> state_q == S_UPDATE)
		else $error("update completed while the result register was full");

	// A captured request always proceeds to lookup.
	a_capture_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_LOOKUP)
		else $error("captured request did not enter lookup");

	// Every commit presents a result in the following cycle.
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not present a result");

endmodule

// File: src/lkvc_datapath.sv
// -----------------------------------------------------------------------------
// lkvc_datapath
// Datapath: request registers, capacity register, the entry table with
// recency ranks, the parallel key compare, the replacement decision and
// the result register.
// -----------------------------------------------------------------------------
module lkvc_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  lkvc_pkg::cmd_t cmd,
	input  logic           cfg_we,
	input  lkvc_pkg::cap_t cfg_wdata,
	input  logic           opcode,
	input  lkvc_pkg::data_t key,
	input  lkvc_pkg::data_t value,
	output logic           hit,
	output lkvc_pkg::data_t read_value,
	output logic           evicted
);
	import lkvc_pkg::*;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_HIT,
		ACT_FILL,
		ACT_EVICT
	} action_t;

	// Request and configuration registers.
	logic  op_q;
	data_t key_q;
	data_t val_q;
	cap_t  cap_q;

	// Entry table.
	logic [ENTRIES-1:0] valid_q;
	data_t              key_tbl_q [ENTRIES];
	data_t              val_tbl_q [ENTRIES];
	idx_t               rank_q    [ENTRIES];
	cnt_t               fill_q;

	// Lookup outcome.
	action_t act_s1;
	idx_t    slot_s1;
	idx_t    rank_s1;
	data_t   rdval_s1;

	// Result register.
	logic  hit_q;
	data_t read_value_q;
	logic  evicted_q;

	// Combinational lookup signals.
	logic [ENTRIES-1:0] match_vec;
	logic               found;
	logic               any_free;
	idx_t               found_idx;
	idx_t               free_idx;
	idx_t               victim_idx;
	idx_t               oldest_rank;
	cnt_t               fill_m1;
	logic [CMP_W-1:0]   cap_ext;
	logic [CMP_W-1:0]   eff_cap;
	action_t            act_next;
	idx_t               slot_next;
	idx_t               rank_next;

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			key_q <= key;
			val_q <= value;
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Capacity zero behaves as one; capacity beyond the table is clipped.
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	// Parallel key compare and slot search. Valid ranks are always the
	// distinct values 0 to fill-1, so the oldest entry holds rank fill-1.
	always_comb begin
		fill_m1     = fill_q - CNT_W'(1);
		oldest_rank = fill_m1[IDX_W-1:0];
		found_idx   = '0;
		free_idx    = '0;
		victim_idx  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = valid_q[i] && (key_tbl_q[i] == key_q);
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_vec[i]) found_idx = IDX_W'(i);
			if (!valid_q[i]) free_idx = IDX_W'(i);
			if (valid_q[i] && (rank_q[i] == oldest_rank)) victim_idx = IDX_W'(i);
		end
		found    = |match_vec;
		any_free = !(&valid_q);
	end

	// Replacement decision.
	always_comb begin
		act_next  = ACT_NONE;
		slot_next = found_idx;
		rank_next = rank_q[found_idx];
		if (found) begin
			act_next = ACT_HIT;
		end else if (op_q == OP_PUT) begin
			if ((CMP_W'(fill_q) < eff_cap) && any_free) begin
				act_next  = ACT_FILL;
				slot_next = free_idx;
			end else if (fill_q != '0) begin
				act_next  = ACT_EVICT;
				slot_next = victim_idx;
				rank_next = oldest_rank;
			end
		end
	end

	// Lookup stage registers.
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			act_s1   <= act_next;
			slot_s1  <= slot_next;
			rank_s1  <= rank_next;
			rdval_s1 <= val_tbl_q[found_idx];
		end
	end

	// Valid bits, recency ranks and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			case (act_s1) inside
				ACT_HIT, ACT_EVICT: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (IDX_W'(i) == slot_s1) begin
							rank_q[i] <= '0;
						end else if (valid_q[i] && (rank_q[i] < rank_s1)) begin
							rank_q[i] <= rank_q[i] + IDX_W'(1);
						end
					end
				end
				ACT_FILL: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (IDX_W'(i) == slot_s1) begin
							rank_q[i] <= '0;
						end else if (valid_q[i]) begin
							rank_q[i] <= rank_q[i] + IDX_W'(1);
						end
					end
					valid_q[slot_s1] <= 1'b1;
					fill_q           <= fill_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Key and value storage.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			case (act_s1) inside
				ACT_HIT: begin
					if (op_q == OP_PUT) val_tbl_q[slot_s1] <= val_q;
				end
				ACT_FILL, ACT_EVICT: begin
					key_tbl_q[slot_s1] <= key_q;
					val_tbl_q[slot_s1] <= val_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q        <= (act_s1 == ACT_HIT);
			evicted_q    <= (act_s1 == ACT_EVICT);
			read_value_q <= ((act_s1 == ACT_HIT) && (op_q == OP_GET)) ? rdval_s1 : '0;
		end
	end

	assign hit        = hit_q;
	assign read_value = read_value_q;
	assign evicted    = evicted_q;

	// The fill count always equals the number of valid entries.
	a_fill_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(fill_q))
		else $error("fill count differs from the number of valid entries");

	// Filling a free entry grows the fill count by one.
	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (act_s1 == ACT_FILL) |=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("fill did not grow the fill count");

	// An eviction leaves the fill count and valid bits where they were.
	a_evict_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (act_s1 == ACT_EVICT) |=> $stable(valid_q) && $stable(fill_q))
		else $error("eviction changed the table occupancy");

endmodule

// File: src/lru_key_value_cache_unit.sv
// A result is presented once its request has passed the lookup and update
// states. The compare-then-update sequence on the single entry table takes
// the next request only when the current one ends; a stalled result holds it.
// The table lives in flip-flops, so there is no clearing pass after reset.
// Reset clears the valid bits, recency ranks and fill count, and sets the
// capacity register to sixteen; stored keys and values are not reset.
// -----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// Each request is a get or a put and yields exactly one result.
// -----------------------------------------------------------------------------
module lru_key_value_cache_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  lkvc_pkg::cap_t  cfg_wdata,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            opcode,
	input  lkvc_pkg::data_t key,
	input  lkvc_pkg::data_t value,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            hit,
	output lkvc_pkg::data_t read_value,
	output logic            evicted
);
	import lkvc_pkg::*;

	cmd_t cmd;

	// Controller.
	lkvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Datapath.
	lkvc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.opcode     (opcode),
		.key        (key),
		.value      (value),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted)
	);

endmodule
